// ----- rtl/sfaf_pkg.sv -----
// Shared types, constants and codes for the subnet free address finder.
`timescale 1ns / 1ps

package sfaf_pkg;

   // Number of entries in the used-address table, one per cell.
   localparam int unsigned TABLE_DEPTH = 32;
   // Width of the fill count, which must hold TABLE_DEPTH itself.
   localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
   // Width of the candidate counter, which must hold TABLE_DEPTH + 1.
   localparam int unsigned ISSUE_W = $clog2(TABLE_DEPTH + 2);

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ISSUE_W-1:0] issue_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // Request codes.
   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_RECORD  = 2'd1;
   localparam logic [1:0] REQ_FIND    = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBNET_MASK  = 1'd1;

   localparam addr_type HOST_ADDRESS_RESET = 32'h0000_0000;
   localparam addr_type SUBNET_MASK_RESET  = 32'hFFFF_FF00;

   typedef struct packed {
      logic [1:0] req_type;
      addr_type   used_address;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      addr_type   free_address;
   } rsp_payload_type;

   // Candidate probe that travels down the row of cells.
   typedef struct packed {
      logic     valid;
      logic     hit;
      logic     last;
      addr_type cand;
   } probe_type;

endpackage

// ----- rtl/sfaf_cell.sv -----
// One table cell: holds one used address and checks passing probes against it.
`timescale 1ns / 1ps

module sfaf_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 flush,
   input  logic                 shift_en,
   input  sfaf_pkg::addr_type   entry_in,
   input  logic                 active,
   input  sfaf_pkg::probe_type  probe_in,
   output sfaf_pkg::addr_type   entry_out,
   output sfaf_pkg::probe_type  probe_out
);

   sfaf_pkg::addr_type  entry_ff;
   sfaf_pkg::probe_type probe_ff;
   sfaf_pkg::probe_type probe_in_next;

   // A record shifts the table by one cell; the new address enters at cell zero.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   // Mark the probe as a hit when this cell holds a live copy of its address.
   always_comb begin
      probe_in_next     = probe_in;
      probe_in_next.hit = probe_in.hit | (active & (entry_ff == probe_in.cand));
   end

   // Probe stage; a flush drops whatever is in flight.
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   assign entry_out = entry_ff;
   assign probe_out = probe_ff;

endmodule

// ----- rtl/sfaf_chain.sv -----
// Row of table cells that shifts in recorded addresses and passes probes along.
`timescale 1ns / 1ps

module sfaf_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 flush,
   input  logic                 shift_en,
   input  sfaf_pkg::addr_type   shift_data,
   input  sfaf_pkg::count_type  count,
   input  sfaf_pkg::probe_type  probe_in,
   output sfaf_pkg::probe_type  probe_out
);

   sfaf_pkg::addr_type  entry_link [sfaf_pkg::TABLE_DEPTH];
   sfaf_pkg::probe_type probe_link [sfaf_pkg::TABLE_DEPTH + 1];

   assign probe_link[0] = probe_in;

   // Cell k holds a live entry when k is below the fill count.
   for (genvar k = 0; k < sfaf_pkg::TABLE_DEPTH; k++) begin : g_cell
      sfaf_pkg::addr_type entry_src;
      logic               cell_active;

      if (k == 0) begin : g_head
         assign entry_src = shift_data;
      end else begin : g_body
         assign entry_src = entry_link[k-1];
      end

      assign cell_active = (sfaf_pkg::count_type'(k) < count);

      sfaf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .flush     (flush),
         .shift_en  (shift_en),
         .entry_in  (entry_src),
         .active    (cell_active),
         .probe_in  (probe_link[k]),
         .entry_out (entry_link[k]),
         .probe_out (probe_link[k+1])
      );
   end

   assign probe_out = probe_link[sfaf_pkg::TABLE_DEPTH];

endmodule

// ----- rtl/subnet_free_address_finder_top.sv -----
// Top level of the subnet free address finder: control, configuration and cell row.
//
//   Channel  Ports                                    Direction  Handshake
//   request  start, busy, req_payload                 in         start && !busy
//   response rsp_strobe, rsp_payload                  out        strobe, one cycle
//   config   csr_valid, csr_ready, csr_index, csr_data in        csr_valid && csr_ready
//
// Clear, record and unused requests answer in the cycle after acceptance, and so
// does a find whose mask leaves no host candidates.
// A find issues one candidate per cycle (at most fill count + 1 of them) into the
// 32-cell row, each cell registering the probe in turn; the first verdict to leave
// the row without a hit, or the last candidate's verdict, ends the find and sets the
// registered response. busy is high while a find is in progress.
// Reset is synchronous and empties the table; the receiver cannot stall responses.
`timescale 1ns / 1ps

module subnet_free_address_finder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  sfaf_pkg::req_payload_type              req_payload,
   output logic                                   rsp_strobe,
   output sfaf_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sfaf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  sfaf_pkg::addr_type                     csr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                 state_ff;
   sfaf_pkg::addr_type        host_ff;
   sfaf_pkg::addr_type        mask_ff;
   sfaf_pkg::count_type       count_ff;
   sfaf_pkg::addr_type        base_ff;
   sfaf_pkg::addr_type        span_ff;
   sfaf_pkg::issue_type       issue_ff;
   logic                      issuing_ff;
   logic                      rsp_strobe_ff;
   sfaf_pkg::rsp_payload_type rsp_ff;

   logic                      accept;
   logic                      shift_en;
   logic                      flush;
   sfaf_pkg::issue_type       limit;
   logic                      issue_last;
   sfaf_pkg::probe_type       probe_in;
   sfaf_pkg::probe_type       probe_out;
   sfaf_pkg::addr_type        base_in;
   sfaf_pkg::addr_type        span_in;

   assign accept    = start & ~busy;
   assign busy      = (state_ff == ST_SCAN);
   assign csr_ready = 1'b1;
   assign base_in   = host_ff & mask_ff;
   assign span_in   = ~mask_ff;
   assign limit     = sfaf_pkg::issue_type'(count_ff) + sfaf_pkg::issue_type'(1);

   // A record enters the row only while the table has room.
   assign shift_en = accept && (req_payload.req_type == sfaf_pkg::REQ_RECORD) &&
                     (count_ff < sfaf_pkg::count_type'(sfaf_pkg::TABLE_DEPTH));

   // The candidate in flight is the last when it reaches the bound or the span.
   assign issue_last = (issue_ff == limit) ||
                       ((sfaf_pkg::addr_type'(issue_ff) + 32'd1) == span_ff);

   always_comb begin
      probe_in       = '0;
      probe_in.valid = (state_ff == ST_SCAN) && issuing_ff;
      probe_in.last  = issue_last;
      probe_in.cand  = base_ff + sfaf_pkg::addr_type'(issue_ff);
   end

   // Once a verdict without a hit, or the last candidate's verdict, leaves the row, the rest of the find is discarded.
   assign flush = (state_ff == ST_SCAN) && probe_out.valid &&
                  (!probe_out.hit || probe_out.last);

   sfaf_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .flush      (flush),
      .shift_en   (shift_en),
      .shift_data (req_payload.used_address),
      .count      (count_ff),
      .probe_in   (probe_in),
      .probe_out  (probe_out)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff <= sfaf_pkg::HOST_ADDRESS_RESET;
         mask_ff <= sfaf_pkg::SUBNET_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sfaf_pkg::CSR_HOST_ADDRESS: host_ff <= csr_data;
            sfaf_pkg::CSR_SUBNET_MASK:  mask_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Control state, fill count and the registered response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issuing_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_ff.status       <= sfaf_pkg::STATUS_OK;
                  rsp_ff.free_address <= '0;
                  unique case (req_payload.req_type)
                     sfaf_pkg::REQ_CLEAR: begin
                        count_ff      <= '0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     sfaf_pkg::REQ_RECORD: begin
                        if (shift_en) begin
                           count_ff <= count_ff + sfaf_pkg::count_type'(1);
                        end else begin
                           rsp_ff.status <= sfaf_pkg::STATUS_FULL;
                        end
                        rsp_strobe_ff <= 1'b1;
                     end
                     sfaf_pkg::REQ_FIND: begin
                        if (span_in < 32'd2) begin
                           rsp_ff.status <= sfaf_pkg::STATUS_NO_FREE;
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           base_ff    <= base_in;
                           span_ff    <= span_in;
                           issue_ff   <= sfaf_pkg::issue_type'(1);
                           issuing_ff <= 1'b1;
                           state_ff   <= ST_SCAN;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // Issue the next candidate until the last one is in the row.
               if (issuing_ff) begin
                  if (issue_last) begin
                     issuing_ff <= 1'b0;
                  end else begin
                     issue_ff <= issue_ff + sfaf_pkg::issue_type'(1);
                  end
               end
               // The first candidate out without a hit is the answer; else the find reports no free address.
               if (flush) begin
                  issuing_ff    <= 1'b0;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
                  if (!probe_out.hit) begin
                     rsp_ff.status       <= sfaf_pkg::STATUS_OK;
                     rsp_ff.free_address <= probe_out.cand;
                  end else begin
                     rsp_ff.status       <= sfaf_pkg::STATUS_NO_FREE;
                     rsp_ff.free_address <= '0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/sfaf_checker.sv -----
// Port-level checks for the subnet free address finder, bound to the top level.
`timescale 1ns / 1ps

module sfaf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input sfaf_pkg::req_payload_type req_payload,
   input logic                      rsp_strobe,
   input sfaf_pkg::rsp_payload_type rsp_payload
);

   // A clear transaction answers in the next cycle with a plain success.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_payload.req_type == sfaf_pkg::REQ_CLEAR) |=>
         rsp_strobe && (rsp_payload.status == sfaf_pkg::STATUS_OK) &&
         (rsp_payload.free_address == '0))
      else $error("clear transaction did not answer with success");

   // Failed transactions never carry an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.status != sfaf_pkg::STATUS_OK) |->
         (rsp_payload.free_address == '0))
      else $error("failure response carries a nonzero address");

   // A find either answers at once or holds the block busy.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_payload.req_type == sfaf_pkg::REQ_FIND) |=>
         rsp_strobe || busy)
      else $error("find transaction neither answered nor started a search");

   // A search ends only together with its response.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("search ended without a response");

   // No response appears while a search is still running.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response during a search");

endmodule

bind subnet_free_address_finder_top sfaf_checker u_sfaf_checker (.*);
